[rtl/orfs_pkg.sv]
// ----------------------------------------------------------------------------
// orfs_pkg: shared types and constants of the rectangle fill sequencer
// Request and response items, sequencer state, and the init byte table.
// ----------------------------------------------------------------------------
package orfs_pkg;

	localparam int unsigned DISPLAY_SIZE_DEF = 128;
	localparam int unsigned INIT_LEN         = 48;
	localparam int unsigned COORD_W          = 7;
	localparam int unsigned COORD_MAX        = 127;

	localparam logic [7:0] OP_COL_WINDOW = 8'h15;
	localparam logic [7:0] OP_ROW_WINDOW = 8'h75;
	localparam logic [7:0] OP_WRITE_RAM  = 8'h5c;

	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		CMD_NEXT  = 2'd0,
		CMD_INIT  = 2'd1,
		CMD_FILL  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_INIT   = 2'd1,
		MODE_HEADER = 2'd2,
		MODE_PIXELS = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]  command;
		coord_t      col_first;
		coord_t      row_first;
		coord_t      col_last;
		coord_t      row_last;
		logic [15:0] fill_colour;
	} req_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       is_command;
		logic       byte_valid;
		logic       seq_last;
	} rsp_t;

	typedef struct packed {
		mode_t       mode;
		logic [5:0]  seq_index;
		coord_t      col_count;
		coord_t      row_count;
		logic        low_phase;
		coord_t      col_first;
		coord_t      row_first;
		coord_t      col_last;
		coord_t      row_last;
		logic [15:0] colour;
	} seq_state_t;

	// Bit 8 marks a command byte, bits 7:0 are the byte itself.
	function automatic logic [8:0] init_entry(input logic [5:0] idx);
		logic [8:0] e;
		unique case (idx)
			6'd0:  e = 9'h1fd;
			6'd1:  e = 9'h012;
			6'd2:  e = 9'h1fd;
			6'd3:  e = 9'h0b1;
			6'd4:  e = 9'h1ae;
			6'd5:  e = 9'h1a4;
			6'd6:  e = 9'h115;
			6'd7:  e = 9'h000;
			6'd8:  e = 9'h07f;
			6'd9:  e = 9'h175;
			6'd10: e = 9'h000;
			6'd11: e = 9'h07f;
			6'd12: e = 9'h1b3;
			6'd13: e = 9'h0f1;
			6'd14: e = 9'h1ca;
			6'd15: e = 9'h07f;
			6'd16: e = 9'h1a0;
			6'd17: e = 9'h066;
			6'd18: e = 9'h1a1;
			6'd19: e = 9'h000;
			6'd20: e = 9'h1a2;
			6'd21: e = 9'h000;
			6'd22: e = 9'h1ab;
			6'd23: e = 9'h001;
			6'd24: e = 9'h1b4;
			6'd25: e = 9'h0a0;
			6'd26: e = 9'h0b5;
			6'd27: e = 9'h055;
			6'd28: e = 9'h1c1;
			6'd29: e = 9'h0c8;
			6'd30: e = 9'h080;
			6'd31: e = 9'h0c0;
			6'd32: e = 9'h1c7;
			6'd33: e = 9'h00f;
			6'd34: e = 9'h1b1;
			6'd35: e = 9'h032;
			6'd36: e = 9'h1b2;
			6'd37: e = 9'h0a4;
			6'd38: e = 9'h000;
			6'd39: e = 9'h000;
			6'd40: e = 9'h1bb;
			6'd41: e = 9'h017;
			6'd42: e = 9'h1b6;
			6'd43: e = 9'h001;
			6'd44: e = 9'h1be;
			6'd45: e = 9'h005;
			6'd46: e = 9'h1a6;
			default: e = 9'h1af;
		endcase
		return e;
	endfunction

endpackage

[rtl/orfs_step.sv]
// ----------------------------------------------------------------------------
// orfs_step: next-state and response logic of the sequencer
// Takes the current state and one request item, gives the next state and
// the response item for that request.
// ----------------------------------------------------------------------------
module orfs_step #(
	parameter int unsigned DISPLAY_SIZE = orfs_pkg::DISPLAY_SIZE_DEF
) (
	input  orfs_pkg::seq_state_t st,
	input  orfs_pkg::req_t       req,
	output orfs_pkg::seq_state_t st_nxt,
	output orfs_pkg::rsp_t       rsp
);

	localparam int unsigned CLEAR_LAST_INT =
		(DISPLAY_SIZE - 1 > orfs_pkg::COORD_MAX) ? orfs_pkg::COORD_MAX : DISPLAY_SIZE - 1;
	localparam orfs_pkg::coord_t CLEAR_LAST = orfs_pkg::COORD_W'(CLEAR_LAST_INT);
	localparam logic [5:0] INIT_LAST_IDX = 6'(orfs_pkg::INIT_LEN - 1);

	logic [8:0] init_e;
	logic [5:0] idx_inc;
	logic       empty_rect;

	assign init_e     = orfs_pkg::init_entry(st.seq_index);
	assign idx_inc    = st.seq_index + 6'd1;
	assign empty_rect = (st.col_first > st.col_last) || (st.row_first > st.row_last);

	always_comb begin
		st_nxt = st;
		rsp    = '0;
		unique case (orfs_pkg::cmd_t'(req.command))
			orfs_pkg::CMD_INIT: begin
				st_nxt.mode      = orfs_pkg::MODE_INIT;
				st_nxt.seq_index = '0;
			end
			orfs_pkg::CMD_FILL, orfs_pkg::CMD_CLEAR: begin
				st_nxt.mode      = orfs_pkg::MODE_HEADER;
				st_nxt.seq_index = '0;
				st_nxt.col_count = '0;
				st_nxt.row_count = '0;
				st_nxt.low_phase = 1'b0;
				if (req.command == orfs_pkg::CMD_FILL) begin
					st_nxt.col_first = req.col_first;
					st_nxt.row_first = req.row_first;
					st_nxt.col_last  = req.col_last;
					st_nxt.row_last  = req.row_last;
					st_nxt.colour    = req.fill_colour;
				end else begin
					st_nxt.col_first = '0;
					st_nxt.row_first = '0;
					st_nxt.col_last  = CLEAR_LAST;
					st_nxt.row_last  = CLEAR_LAST;
					st_nxt.colour    = '0;
				end
			end
			orfs_pkg::CMD_NEXT: begin
				unique case (st.mode)
					orfs_pkg::MODE_IDLE: begin
					end
					orfs_pkg::MODE_INIT: begin
						rsp.byte_out   = init_e[7:0];
						rsp.is_command = init_e[8];
						rsp.byte_valid = 1'b1;
						if (st.seq_index >= INIT_LAST_IDX) begin
							rsp.seq_last     = 1'b1;
							st_nxt.mode      = orfs_pkg::MODE_IDLE;
							st_nxt.seq_index = '0;
						end else begin
							st_nxt.seq_index = idx_inc;
						end
					end
					orfs_pkg::MODE_HEADER: begin
						rsp.byte_valid = 1'b1;
						unique case (st.seq_index)
							6'd0: begin
								rsp.byte_out   = orfs_pkg::OP_COL_WINDOW;
								rsp.is_command = 1'b1;
							end
							6'd1: rsp.byte_out = {1'b0, st.col_first};
							6'd2: rsp.byte_out = {1'b0, st.col_last};
							6'd3: begin
								rsp.byte_out   = orfs_pkg::OP_ROW_WINDOW;
								rsp.is_command = 1'b1;
							end
							6'd4: rsp.byte_out = {1'b0, st.row_first};
							6'd5: rsp.byte_out = {1'b0, st.row_last};
							default: begin
								rsp.byte_out   = orfs_pkg::OP_WRITE_RAM;
								rsp.is_command = 1'b1;
							end
						endcase
						if (st.seq_index >= 6'd6) begin
							st_nxt.seq_index = '0;
							if (empty_rect) begin
								// Empty window: the write-memory byte closes the sequence.
								rsp.seq_last = 1'b1;
								st_nxt.mode  = orfs_pkg::MODE_IDLE;
							end else begin
								st_nxt.mode      = orfs_pkg::MODE_PIXELS;
								st_nxt.col_count = st.col_first;
								st_nxt.row_count = st.row_first;
								st_nxt.low_phase = 1'b0;
							end
						end else begin
							st_nxt.seq_index = idx_inc;
						end
					end
					orfs_pkg::MODE_PIXELS: begin
						rsp.byte_valid = 1'b1;
						if (!st.low_phase) begin
							rsp.byte_out     = st.colour[15:8];
							st_nxt.low_phase = 1'b1;
						end else begin
							rsp.byte_out     = st.colour[7:0];
							st_nxt.low_phase = 1'b0;
							if (st.col_count >= st.col_last) begin
								if (st.row_count >= st.row_last) begin
									rsp.seq_last = 1'b1;
									st_nxt.mode  = orfs_pkg::MODE_IDLE;
								end else begin
									st_nxt.row_count = st.row_count + 7'd1;
								end
								st_nxt.col_count = st.col_first;
							end else begin
								st_nxt.col_count = st.col_count + 7'd1;
							end
						end
					end
				endcase
			end
		endcase
	end

endmodule

[rtl/oled_rect_fill_sequencer.sv]
// ----------------------------------------------------------------------------
// oled_rect_fill_sequencer: byte stream generator for a display controller
// Init, rectangle fill and clear sequences, one byte per next request.
//
//   Channel  Signals                      Carries
//   req      req_valid, req_ready, req    one request item (orfs_pkg::req_t)
//   rsp      rsp_valid, rsp_ready, rsp    one response item (orfs_pkg::rsp_t)
//
// Every request yields one response, registered and shown in the cycle after it is accepted.
// A request is taken each cycle while the response register is empty or
// being drained; the only stall comes from rsp_ready held low.
// The state registers and the response register form the single stage.
// Reset clears the sequencer to idle and empties the response register.
// ----------------------------------------------------------------------------
module oled_rect_fill_sequencer #(
	parameter int unsigned DISPLAY_SIZE = orfs_pkg::DISPLAY_SIZE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  orfs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output orfs_pkg::rsp_t rsp
);

	orfs_pkg::seq_state_t st_q;
	orfs_pkg::seq_state_t st_nxt;
	orfs_pkg::rsp_t       rsp_nxt;
	orfs_pkg::rsp_t       rsp_q;
	logic                 rsp_valid_q;
	logic                 req_fire;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	orfs_step #(
		.DISPLAY_SIZE(DISPLAY_SIZE)
	) u_step (
		.st    (st_q),
		.req   (req),
		.st_nxt(st_nxt),
		.rsp   (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				st_q <= st_nxt;
			end
			if (req_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q <= rsp_nxt;
		end
	end

	// A start request answers with an empty response item.
	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.command != orfs_pkg::CMD_NEXT) |=> rsp_valid && !rsp.byte_valid)
		else $error("start request did not give an empty response");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.byte_valid |->
			(rsp.byte_out == 8'd0) && !rsp.is_command && !rsp.seq_last)
		else $error("response without a byte carries nonzero fields");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.seq_last |-> rsp.byte_valid)
		else $error("last flag on a response without a byte");

	a_pixel_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == orfs_pkg::MODE_PIXELS |->
			(st_q.col_count <= st_q.col_last) && (st_q.row_count <= st_q.row_last))
		else $error("pixel counters left the window");

	a_init_index: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == orfs_pkg::MODE_INIT |-> st_q.seq_index < 6'(orfs_pkg::INIT_LEN))
		else $error("init index past the end of the table");

endmodule

[sim/oled_rect_fill_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_rect_fill_sequencer_tb: self-checking bench for the byte sequencer
// Drives init, fill, clear and next requests with random gaps on both
// channels. A scoreboard predicts every response byte and compares each one
// in order as it leaves the block.
// ----------------------------------------------------------------------------
module oled_rect_fill_sequencer_tb;
	import orfs_pkg::*;

	localparam int unsigned DISPLAY_SIZE = DISPLAY_SIZE_DEF;
	localparam coord_t CLEAR_LAST =
		coord_t'((DISPLAY_SIZE - 1 > COORD_MAX) ? COORD_MAX : DISPLAY_SIZE - 1);
	localparam int RANDOM_ITEMS = 1850;

	// Power-up bytes, first entry in the top bits; bit 8 marks a command byte.
	localparam logic [9*48-1:0] POWER_UP_BYTES = {
		9'h1fd, 9'h012, 9'h1fd, 9'h0b1, 9'h1ae, 9'h1a4,
		9'h115, 9'h000, 9'h07f, 9'h175, 9'h000, 9'h07f,
		9'h1b3, 9'h0f1, 9'h1ca, 9'h07f, 9'h1a0, 9'h066,
		9'h1a1, 9'h000, 9'h1a2, 9'h000, 9'h1ab, 9'h001,
		9'h1b4, 9'h0a0, 9'h0b5, 9'h055, 9'h1c1, 9'h0c8,
		9'h080, 9'h0c0, 9'h1c7, 9'h00f, 9'h1b1, 9'h032,
		9'h1b2, 9'h0a4, 9'h000, 9'h000, 9'h1bb, 9'h017,
		9'h1b6, 9'h001, 9'h1be, 9'h005, 9'h1a6, 9'h1af
	};

	class byte_stream_board;
		mode_t       mode;
		logic [5:0]  index;
		coord_t      col_cnt;
		coord_t      row_cnt;
		logic        low_next;
		coord_t      win_cf;
		coord_t      win_rf;
		coord_t      win_cl;
		coord_t      win_rl;
		logic [15:0] colour;
		rsp_t        pending[$];
		int          errors;

		function new();
			mode     = MODE_IDLE;
			index    = '0;
			col_cnt  = '0;
			row_cnt  = '0;
			low_next = 1'b0;
			win_cf   = '0;
			win_rf   = '0;
			win_cl   = '0;
			win_rl   = '0;
			colour   = '0;
			errors   = 0;
		endfunction

		function void load_window(coord_t cf, coord_t rf, coord_t cl, coord_t rl,
				logic [15:0] c);
			win_cf   = cf;
			win_rf   = rf;
			win_cl   = cl;
			win_rl   = rl;
			colour   = c;
			mode     = MODE_HEADER;
			index    = '0;
			col_cnt  = '0;
			row_cnt  = '0;
			low_next = 1'b0;
		endfunction

		function void note_request(req_t r);
			rsp_t       e;
			logic [8:0] entry;
			e = '0;
			case (cmd_t'(r.command))
				CMD_INIT: begin
					mode  = MODE_INIT;
					index = '0;
				end
				CMD_FILL: load_window(r.col_first, r.row_first, r.col_last, r.row_last,
					r.fill_colour);
				CMD_CLEAR: load_window('0, '0, CLEAR_LAST, CLEAR_LAST, 16'h0000);
				default: begin
					case (mode)
						MODE_INIT: begin
							entry = (int'(index) < INIT_LEN) ?
								POWER_UP_BYTES[9*(INIT_LEN-1-int'(index)) +: 9] : 9'h1af;
							e.byte_out   = entry[7:0];
							e.is_command = entry[8];
							e.byte_valid = 1'b1;
							if (int'(index) + 1 >= INIT_LEN) begin
								e.seq_last = 1'b1;
								mode       = MODE_IDLE;
								index      = '0;
							end else begin
								index = index + 6'd1;
							end
						end
						MODE_HEADER: begin
							e.byte_valid = 1'b1;
							case (index)
								6'd0: begin
									e.byte_out   = OP_COL_WINDOW;
									e.is_command = 1'b1;
								end
								6'd1: e.byte_out = {1'b0, win_cf};
								6'd2: e.byte_out = {1'b0, win_cl};
								6'd3: begin
									e.byte_out   = OP_ROW_WINDOW;
									e.is_command = 1'b1;
								end
								6'd4: e.byte_out = {1'b0, win_rf};
								6'd5: e.byte_out = {1'b0, win_rl};
								default: begin
									e.byte_out   = OP_WRITE_RAM;
									e.is_command = 1'b1;
								end
							endcase
							if (index >= 6'd6) begin
								index = '0;
								// An inverted window ends the sequence on the write command.
								if (win_cf > win_cl || win_rf > win_rl) begin
									e.seq_last = 1'b1;
									mode       = MODE_IDLE;
								end else begin
									mode     = MODE_PIXELS;
									col_cnt  = win_cf;
									row_cnt  = win_rf;
									low_next = 1'b0;
								end
							end else begin
								index = index + 6'd1;
							end
						end
						MODE_PIXELS: begin
							e.byte_valid = 1'b1;
							if (!low_next) begin
								e.byte_out = colour[15:8];
								low_next   = 1'b1;
							end else begin
								e.byte_out = colour[7:0];
								low_next   = 1'b0;
								if (col_cnt >= win_cl) begin
									if (row_cnt >= win_rl) begin
										e.seq_last = 1'b1;
										mode       = MODE_IDLE;
									end else begin
										row_cnt = row_cnt + 7'd1;
									end
									col_cnt = win_cf;
								end else begin
									col_cnt = col_cnt + 7'd1;
								end
							end
						end
						default: ;
					endcase
				end
			endcase
			pending.push_back(e);
		endfunction

		function void check_byte(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				$error("response %h arrived with no request outstanding", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.byte_out !== want.byte_out) begin
				$error("byte_out: expected %h, actual %h", want.byte_out, got.byte_out);
				errors++;
			end
			if (got.is_command !== want.is_command) begin
				$error("is_command: expected %b, actual %b", want.is_command, got.is_command);
				errors++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %b, actual %b", want.byte_valid, got.byte_valid);
				errors++;
			end
			if (got.seq_last !== want.seq_last) begin
				$error("seq_last: expected %b, actual %b", want.seq_last, got.seq_last);
				errors++;
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	bit               calm = 1'b0;
	int               items_sent = 0;
	byte_stream_board board;

	oled_rect_fill_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ready = calm || ($urandom_range(0, 99) >= 24);
	end

	// The response leaving at this edge belongs to an earlier request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				board.check_byte(rsp);
			if (req_valid && req_ready)
				board.note_request(req);
		end
	end

	function automatic req_t any_req(cmd_t c);
		req_t r;
		r.command     = c;
		r.col_first   = coord_t'($urandom_range(0, COORD_MAX));
		r.row_first   = coord_t'($urandom_range(0, COORD_MAX));
		r.col_last    = coord_t'($urandom_range(0, COORD_MAX));
		r.row_last    = coord_t'($urandom_range(0, COORD_MAX));
		r.fill_colour = 16'($urandom_range(0, 65535));
		return r;
	endfunction

	function automatic req_t fill_req(coord_t cf, coord_t rf, coord_t cl, coord_t rl,
			logic [15:0] c);
		req_t r;
		r = any_req(CMD_FILL);
		r.col_first   = cf;
		r.row_first   = rf;
		r.col_last    = cl;
		r.row_last    = rl;
		r.fill_colour = c;
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(input req_t r);
		while (!calm && $urandom_range(0, 99) < 24) begin
			req_valid = 1'b0;
			req       = any_req(cmd_t'($urandom_range(0, 3)));
			@(negedge clk);
		end
		req_valid = 1'b1;
		req       = r;
		do @(posedge clk); while (!req_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_nexts(input int n);
		repeat (n) send_request(any_req(CMD_NEXT));
	endtask

	task automatic wait_drained();
		req_valid = 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		int     base;
		int     pick;
		int     n;
		int     w;
		int     h;
		int     pixels;
		bit     paused;
		coord_t cf;
		coord_t rf;
		coord_t cl;
		coord_t rl;

		board  = new();
		paused = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Next while idle, a one-pixel fill in the far corner, an inverted
		// window, and a start that aborts a running init sequence.
		send_nexts(1);
		send_request(fill_req(7'd127, 7'd127, 7'd127, 7'd127, 16'hffff));
		send_nexts(10);
		send_request(fill_req(7'd5, 7'd0, 7'd4, 7'd127, 16'h0000));
		send_nexts(7);
		send_request(any_req(CMD_INIT));
		send_nexts(2);
		send_request(any_req(CMD_CLEAR));
		send_nexts(2);
		wait_drained();

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			calm = (items_sent - base >= 400) && (items_sent - base < 700);
			if (!paused && items_sent - base >= 900) begin
				paused = 1'b1;
				wait_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				send_request(any_req(CMD_INIT));
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 47) :
					48 + $urandom_range(0, 2);
				send_nexts(n);
			end else if (pick < 70) begin
				if ($urandom_range(0, 19) == 0) begin
					w = $urandom_range(0, 127);
					h = $urandom_range(0, 1);
				end else begin
					w = $urandom_range(0, 3);
					h = $urandom_range(0, 3);
				end
				cf = coord_t'($urandom_range(0, COORD_MAX));
				rf = coord_t'($urandom_range(0, COORD_MAX));
				cl = coord_t'((int'(cf) + w > COORD_MAX) ? COORD_MAX : int'(cf) + w);
				rl = coord_t'((int'(rf) + h > COORD_MAX) ? COORD_MAX : int'(rf) + h);
				if ($urandom_range(0, 7) == 0) begin
					if ($urandom_range(0, 1) == 0 && cf > 0)
						cl = coord_t'($urandom_range(0, int'(cf) - 1));
					else if (rf > 0)
						rl = coord_t'($urandom_range(0, int'(rf) - 1));
				end
				pixels = (cf > cl || rf > rl) ? 0 :
					(int'(cl) - int'(cf) + 1) * (int'(rl) - int'(rf) + 1);
				send_request(fill_req(cf, rf, cl, rl, 16'($urandom_range(0, 65535))));
				n = 7 + 2 * pixels + $urandom_range(0, 2);
				if ($urandom_range(0, 5) == 0)
					n = $urandom_range(0, n - 1);
				send_nexts(n);
			end else if (pick < 78) begin
				send_request(any_req(CMD_CLEAR));
				// Some clears run past the end of the first row.
				n = ($urandom_range(0, 3) == 0) ? 7 + 256 + $urandom_range(0, 10) :
					$urandom_range(0, 20);
				send_nexts(n);
			end else begin
				repeat ($urandom_range(1, 4))
					send_request(any_req(cmd_t'($urandom_range(0, 3))));
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (4) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[filelist.f]
rtl/orfs_pkg.sv
rtl/orfs_step.sv
rtl/oled_rect_fill_sequencer.sv
sim/oled_rect_fill_sequencer_tb.sv
